// ===== src/mrr_pkg.sv =====
// Package for the Modbus RTU response receiver: action and status codes,
// CRC-16/Modbus constants, register indexes and field widths. No dependencies.
package mrr_pkg;

   localparam int MAX_FRAME = 16;

   localparam int BYTE_W   = 8;
   localparam int INDEX_W  = 5;
   localparam int CRC_W    = 16;
   localparam int TICK_W   = 16;
   localparam int LENGTH_W = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
   localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

   localparam logic [BYTE_W-1:0]   SLAVE_ADDRESS_RESET = 8'd1;
   localparam logic [BYTE_W-1:0]   FUNCTION_CODE_RESET = 8'd3;
   localparam logic [LENGTH_W-1:0] FRAME_LENGTH_RESET  = 5'd7;
   localparam logic [TICK_W-1:0]   TIMEOUT_TICKS_RESET = 16'd200;
   localparam logic [LENGTH_W-1:0] MIN_GOOD_LENGTH     = 5'd4;

   typedef enum logic [1:0] {
      ACTION_START = 2'd0,
      ACTION_BYTE  = 2'd1,
      ACTION_TICK  = 2'd2,
      ACTION_NONE  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STATUS_COLLECTING = 2'd0,
      STATUS_GOOD       = 2'd1,
      STATUS_CRC_ERROR  = 2'd2,
      STATUS_TIMEOUT    = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SLAVE_ADDRESS = 2'd0,
      CSR_FUNCTION_CODE = 2'd1,
      CSR_FRAME_LENGTH  = 2'd2,
      CSR_TIMEOUT_TICKS = 2'd3
   } csr_index_type;

endpackage

// ===== src/mrr_if.sv =====
// Valid/ready channel interfaces for the receiver's item and result streams.
// Depends on mrr_pkg.
interface mrr_req_if;
   import mrr_pkg::*;
   logic        valid;
   logic        ready;
   action_type  action;
   logic [BYTE_W-1:0] byte_in;

   modport source (output valid, action, byte_in, input ready);
   modport sink   (input valid, action, byte_in, output ready);
endinterface

interface mrr_rsp_if;
   import mrr_pkg::*;
   logic        valid;
   logic        ready;
   logic [BYTE_W-1:0]  byte_out;
   logic [INDEX_W-1:0] byte_index;
   logic        last;
   status_type  status;

   modport source (output valid, byte_out, byte_index, last, status, input ready);
   modport sink   (input valid, byte_out, byte_index, last, status, output ready);
endinterface

// ===== src/mrr_crc16.sv =====
// One-byte CRC-16/Modbus update (reflected, eight bit steps unrolled).
// Depends on mrr_pkg.
module mrr_crc16 (
   input  logic [mrr_pkg::CRC_W-1:0]  crc_seed,
   input  logic [mrr_pkg::BYTE_W-1:0] data_byte,
   output logic [mrr_pkg::CRC_W-1:0]  crc_next
);
   import mrr_pkg::*;

   always_comb begin
      logic [CRC_W-1:0] crc;
      crc = crc_seed ^ {{(CRC_W-BYTE_W){1'b0}}, data_byte};
      for (int k = 0; k < BYTE_W; k++) begin
         if (crc[0]) begin
            crc = (crc >> 1) ^ CRC_POLY;
         end else begin
            crc = crc >> 1;
         end
      end
      crc_next = crc;
   end
endmodule

// ===== src/modbus_rtu_response_receiver.sv =====
// Modbus RTU response receiver: address/function match, CRC-16 check, timeout.
// Path: an item enters the input register; any result it yields goes to the result
// register, which holds it until it transfers.
// Throughput: one item per cycle while the result register is free; the frame state
// updates with the byte-wide CRC step in the cycle an item leaves the input register.
// Reset (synchronous): registers to defaults, receiver idle, both stages empty.
// Depends on mrr_pkg, mrr_if and mrr_crc16.
module modbus_rtu_response_receiver (
   input  logic clock,
   input  logic reset,
   mrr_req_if.sink   req,
   mrr_rsp_if.source rsp,
   input  logic                              csr_write_enable,
   input  logic [mrr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mrr_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import mrr_pkg::*;

   localparam logic [INDEX_W-1:0] FRAME_CAP = INDEX_W'(MAX_FRAME);

   // configuration registers
   logic [BYTE_W-1:0]   slave_address_ff;
   logic [BYTE_W-1:0]   function_code_ff;
   logic [LENGTH_W-1:0] frame_length_ff;
   logic [TICK_W-1:0]   timeout_ticks_ff;

   // input stage
   logic              in_valid_ff, in_valid_in;
   action_type        in_action_ff;
   logic [BYTE_W-1:0] in_byte_ff;

   // frame state
   logic               receiving_ff, receiving_in;
   logic [INDEX_W-1:0] count_ff, count_in;
   logic [CRC_W-1:0]   crc_ff, crc_in;
   logic [TICK_W-1:0]  ticks_ff, ticks_in;

   // result stage
   logic               out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]  out_byte_ff, out_byte_in;
   logic [INDEX_W-1:0] out_index_ff, out_index_in;
   logic               out_last_ff, out_last_in;
   status_type         out_status_ff, out_status_in;

   logic               out_free;
   logic               process;
   logic               produce;
   logic               restart;
   logic               keep;
   logic [INDEX_W-1:0] base_count;
   logic [INDEX_W-1:0] next_count;
   logic [INDEX_W-1:0] limit;
   logic [CRC_W-1:0]   crc_seed;
   logic [CRC_W-1:0]   crc_next;
   logic [TICK_W-1:0]  ticks_sat;

   assign out_free  = !out_valid_ff || rsp.ready;
   assign process   = in_valid_ff && out_free;
   assign req.ready = !in_valid_ff || out_free;

   // wrong function byte: restart the frame from scratch
   assign restart    = (count_ff == INDEX_W'(1)) && (in_byte_ff != function_code_ff);
   assign base_count = restart ? '0 : count_ff;
   assign crc_seed   = restart ? CRC_INIT : crc_ff;
   assign keep       = (base_count != '0) || (in_byte_ff == slave_address_ff);
   assign next_count = base_count + INDEX_W'(1);
   assign limit      = (frame_length_ff > FRAME_CAP) ? FRAME_CAP : frame_length_ff;
   assign ticks_sat  = (ticks_ff == '1) ? ticks_ff : ticks_ff + TICK_W'(1);

   mrr_crc16 crc_unit (
      .crc_seed  (crc_seed),
      .data_byte (in_byte_ff),
      .crc_next  (crc_next)
   );

   always_comb begin
      receiving_in  = receiving_ff;
      count_in      = count_ff;
      crc_in        = crc_ff;
      ticks_in      = ticks_ff;
      produce       = 1'b0;
      out_byte_in   = in_byte_ff;
      out_index_in  = base_count;
      out_last_in   = 1'b0;
      out_status_in = STATUS_COLLECTING;
      if (process) begin
         case (in_action_ff)
            ACTION_START: begin
               receiving_in = 1'b1;
               count_in     = '0;
               crc_in       = CRC_INIT;
               ticks_in     = '0;
            end
            ACTION_TICK: begin
               if (receiving_ff) begin
                  ticks_in = ticks_sat;
                  if (ticks_sat >= timeout_ticks_ff) begin
                     receiving_in  = 1'b0;
                     produce       = 1'b1;
                     out_byte_in   = '0;
                     out_index_in  = count_ff;
                     out_last_in   = 1'b1;
                     out_status_in = STATUS_TIMEOUT;
                  end
               end
            end
            ACTION_BYTE: begin
               if (receiving_ff) begin
                  count_in = base_count;
                  crc_in   = crc_seed;
                  if (keep) begin
                     crc_in   = crc_next;
                     count_in = next_count;
                     produce  = 1'b1;
                     if (next_count >= limit) begin
                        receiving_in  = 1'b0;
                        out_last_in   = 1'b1;
                        out_status_in = (frame_length_ff >= MIN_GOOD_LENGTH &&
                                         crc_next == '0) ? STATUS_GOOD : STATUS_CRC_ERROR;
                     end
                  end
               end
            end
            default: begin
               // unused action: drop
            end
         endcase
      end
   end

   always_comb begin
      if (req.valid && req.ready) begin
         in_valid_in = 1'b1;
      end else if (process) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      out_valid_in = out_free ? (process && produce) : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_address_ff <= SLAVE_ADDRESS_RESET;
         function_code_ff <= FUNCTION_CODE_RESET;
         frame_length_ff  <= FRAME_LENGTH_RESET;
         timeout_ticks_ff <= TIMEOUT_TICKS_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SLAVE_ADDRESS: slave_address_ff <= csr_write_data[BYTE_W-1:0];
            CSR_FUNCTION_CODE: function_code_ff <= csr_write_data[BYTE_W-1:0];
            CSR_FRAME_LENGTH:  frame_length_ff  <= csr_write_data[LENGTH_W-1:0];
            CSR_TIMEOUT_TICKS: timeout_ticks_ff <= csr_write_data[TICK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         receiving_ff <= 1'b0;
         count_ff     <= '0;
         crc_ff       <= CRC_INIT;
         ticks_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         receiving_ff <= receiving_in;
         count_ff     <= count_in;
         crc_ff       <= crc_in;
         ticks_ff     <= ticks_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_action_ff <= req.action;
         in_byte_ff   <= req.byte_in;
      end
      if (process && produce) begin
         out_byte_ff   <= out_byte_in;
         out_index_ff  <= out_index_in;
         out_last_ff   <= out_last_in;
         out_status_ff <= out_status_in;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.byte_out   = out_byte_ff;
   assign rsp.byte_index = out_index_ff;
   assign rsp.last       = out_last_ff;
   assign rsp.status     = out_status_ff;

   // a frame-ending result leaves the receiver idle
   a_end_idles: assert property (@(posedge clock) disable iff (reset)
      (process && produce && out_last_in) |=> !receiving_ff)
      else $error("receiver still active after frame end");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FRAME_CAP)
      else $error("byte count beyond frame cap");

   a_last_status: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_last_ff == (out_status_ff != STATUS_COLLECTING)))
      else $error("last flag disagrees with status");

   a_timeout_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_status_ff == STATUS_TIMEOUT) |-> (out_byte_ff == '0))
      else $error("timeout result carries a byte");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for modbus_rtu_response_receiver: random and directed frames,
// tick timeouts and register settings, checked against a cycle-free frame predictor.
// Depends on mrr_pkg, mrr_if and the receiver RTL.
module tb_top;
   import mrr_pkg::*;

   localparam int ITEM_TARGET   = 950;
   localparam int SETTLE_CYCLES = 6;
   localparam int LONG_STALL    = 400;
   localparam int CYCLE_LIMIT   = 200000;

   typedef struct {
      action_type        action;
      logic [BYTE_W-1:0] data;
   } rx_item_type;

   typedef struct {
      logic [BYTE_W-1:0]  byte_out;
      logic [INDEX_W-1:0] byte_index;
      logic               last;
      status_type         status;
   } frame_result_type;

   logic clock;
   logic reset = 1'b1;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   mrr_req_if req_ch ();
   mrr_rsp_if rsp_ch ();

   modbus_rtu_response_receiver DUT (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Register copies and frame state of the predictor
   logic [BYTE_W-1:0]   cfg_address  = SLAVE_ADDRESS_RESET;
   logic [BYTE_W-1:0]   cfg_function = FUNCTION_CODE_RESET;
   logic [LENGTH_W-1:0] cfg_length   = FRAME_LENGTH_RESET;
   logic [TICK_W-1:0]   cfg_timeout  = TIMEOUT_TICKS_RESET;
   bit                  rx_active = 1'b0;
   int                  rx_count  = 0;
   logic [CRC_W-1:0]    rx_crc    = CRC_INIT;
   logic [TICK_W-1:0]   rx_ticks  = '0;

   rx_item_type      pend_q[$];
   frame_result_type frame_result_q[$];
   logic [BYTE_W-1:0] frame_buf[$];

   int sent_total = 0;
   int accepted_total = 0;
   int err_cnt = 0;
   int cycle_cnt = 0;
   int send_gap, recv_gap, stall_left;
   bit send_burst = 1'b0;
   bit recv_burst = 1'b0;
   bit long_stall_arm = 1'b0;
   bit stall_done;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.action  = ACTION_NONE;
      req_ch.byte_in = '0;
      rsp_ch.ready   = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic logic [CRC_W-1:0] crc16_modbus_step(input logic [CRC_W-1:0] crc,
                                                           input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++)
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
   endfunction

   task automatic push_result(input logic [BYTE_W-1:0] b, input int idx, input logic last,
                              input status_type st);
      frame_result_type r;
      r.byte_out   = b;
      r.byte_index = INDEX_W'(idx);
      r.last       = last;
      r.status     = st;
      frame_result_q.push_back(r);
   endtask

   task automatic modbus_rx_predict(input action_type act, input logic [BYTE_W-1:0] data);
      bit take;
      int limit;
      int idx;
      case (act)
         ACTION_START: begin
            rx_active = 1'b1;
            rx_count  = 0;
            rx_crc    = CRC_INIT;
            rx_ticks  = '0;
         end
         ACTION_TICK: if (rx_active) begin
            if (rx_ticks != 16'hFFFF) rx_ticks = rx_ticks + 1'b1;
            if (rx_ticks >= cfg_timeout) begin
               rx_active = 1'b0;
               push_result(8'h00, rx_count, 1'b1, STATUS_TIMEOUT);
            end
         end
         ACTION_BYTE: if (rx_active) begin
            take = 1'b1;
            if (rx_count == 0) begin
               take = (data == cfg_address);
            end else if (rx_count == 1 && data != cfg_function) begin
               // a byte other than the function code restarts the frame; it is kept if it is the address
               rx_count = 0;
               rx_crc   = CRC_INIT;
               take     = (data == cfg_address);
            end
            if (take) begin
               idx      = rx_count;
               rx_crc   = crc16_modbus_step(rx_crc, data);
               rx_count = rx_count + 1;
               limit    = (int'(cfg_length) > MAX_FRAME) ? MAX_FRAME : int'(cfg_length);
               if (rx_count >= limit) begin
                  rx_active = 1'b0;
                  push_result(data, idx, 1'b1,
                     (cfg_length >= MIN_GOOD_LENGTH && rx_crc == '0) ? STATUS_GOOD
                                                                     : STATUS_CRC_ERROR);
               end else begin
                  push_result(data, idx, 1'b0, STATUS_COLLECTING);
               end
            end
         end
         default: ;
      endcase
   endtask

   // Request driver: one item per transfer, random gap after each
   always @(posedge clock) begin : req_driver
      rx_item_type nxt;
      int g;
      if (reset) begin
         req_ch.valid   <= 1'b0;
         req_ch.action  <= ACTION_NONE;
         req_ch.byte_in <= '0;
         send_gap       <= 0;
      end else begin
         g = 0;
         if (req_ch.valid && req_ch.ready) begin
            modbus_rx_predict(req_ch.action, req_ch.byte_in);
            accepted_total = accepted_total + 1;
            if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
            g = send_burst ? 0 : int'($urandom_range(0, 15));
         end
         if (req_ch.valid && !req_ch.ready) begin
            // hold the current item
         end else if (g > 0) begin
            req_ch.valid <= 1'b0;
            send_gap     <= g - 1;
         end else if (send_gap != 0) begin
            req_ch.valid <= 1'b0;
            send_gap     <= send_gap - 1;
         end else if (pend_q.size() != 0) begin
            nxt = pend_q.pop_front();
            req_ch.valid   <= 1'b1;
            req_ch.action  <= nxt.action;
            req_ch.byte_in <= nxt.data;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Result monitor and ready generator
   always @(posedge clock) begin : rsp_monitor
      frame_result_type want;
      int g;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_gap     <= 0;
         stall_left   <= 0;
         stall_done   <= 1'b0;
      end else begin
         g = 0;
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (frame_result_q.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual %h/%0d/%0d/%0d",
                        $time, rsp_ch.byte_out, rsp_ch.byte_index, rsp_ch.last,
                        rsp_ch.status);
               err_cnt++;
            end else begin
               want = frame_result_q.pop_front();
               if (rsp_ch.byte_out !== want.byte_out) begin
                  $display("%0t: byte_out mismatch: expected %h, actual %h",
                           $time, want.byte_out, rsp_ch.byte_out);
                  err_cnt++;
               end
               if (rsp_ch.byte_index !== want.byte_index) begin
                  $display("%0t: byte_index mismatch: expected %0d, actual %0d",
                           $time, want.byte_index, rsp_ch.byte_index);
                  err_cnt++;
               end
               if (rsp_ch.last !== want.last) begin
                  $display("%0t: last mismatch: expected %0d, actual %0d",
                           $time, want.last, rsp_ch.last);
                  err_cnt++;
               end
               if (rsp_ch.status !== want.status) begin
                  $display("%0t: status mismatch: expected %0d, actual %0d",
                           $time, want.status, rsp_ch.status);
                  err_cnt++;
               end
            end
            if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
            g = recv_burst ? 0 : int'($urandom_range(0, 15));
         end
         if (stall_left != 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
         end else if (long_stall_arm && !stall_done) begin
            // hold off long enough for the receiver to back up into its input
            rsp_ch.ready <= 1'b0;
            stall_left   <= LONG_STALL;
            stall_done   <= 1'b1;
         end else if (g > 0) begin
            rsp_ch.ready <= 1'b0;
            recv_gap     <= g - 1;
         end else if (recv_gap != 0) begin
            rsp_ch.ready <= 1'b0;
            recv_gap     <= recv_gap - 1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic push_item(input action_type act, input logic [BYTE_W-1:0] data);
      rx_item_type it;
      it.action = act;
      it.data   = data;
      pend_q.push_back(it);
      sent_total++;
   endtask

   // Drain: every item transferred, every result back, pipeline empty
   task automatic wait_idle();
      do @(posedge clock);
      while (accepted_total != sent_total || frame_result_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      case (idx)
         CSR_SLAVE_ADDRESS: cfg_address  = value[BYTE_W-1:0];
         CSR_FUNCTION_CODE: cfg_function = value[BYTE_W-1:0];
         CSR_FRAME_LENGTH:  cfg_length   = value[LENGTH_W-1:0];
         CSR_TIMEOUT_TICKS: cfg_timeout  = value[TICK_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_regs(input logic [CSR_DATA_W-1:0] addr, input logic [CSR_DATA_W-1:0] func,
                           input logic [CSR_DATA_W-1:0] len, input logic [CSR_DATA_W-1:0] tmo);
      set_reg(CSR_SLAVE_ADDRESS, addr);
      set_reg(CSR_FUNCTION_CODE, func);
      set_reg(CSR_FRAME_LENGTH, len);
      set_reg(CSR_TIMEOUT_TICKS, tmo);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Append CRC to frame_buf and queue it; a rough frame gets a start, damage and ticks
   task automatic push_frame(input bit rough, input bit bad_crc);
      logic [CRC_W-1:0] crc;
      int pos;
      crc = CRC_INIT;
      foreach (frame_buf[k]) crc = crc16_modbus_step(crc, frame_buf[k]);
      frame_buf.push_back(crc[7:0]);
      frame_buf.push_back(bad_crc ? ~crc[15:8] : crc[15:8]);
      if (rough) begin
         if ($urandom_range(0, 7) == 0) begin
            pos = $urandom_range(0, frame_buf.size() - 1);
            frame_buf[pos] = frame_buf[pos] ^ 8'($urandom_range(1, 255));
         end
         if ($urandom_range(0, 7) == 0) frame_buf.insert(1, frame_buf[0]);
         push_item(ACTION_START, 8'($urandom_range(0, 255)));
         if ($urandom_range(0, 5) == 0) push_item(ACTION_BYTE, 8'($urandom_range(0, 255)));
      end
      foreach (frame_buf[k]) begin
         if (rough && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 3)) push_item(ACTION_TICK, 8'($urandom_range(0, 255)));
         push_item(ACTION_BYTE, frame_buf[k]);
      end
      frame_buf = {};
   endtask

   task automatic gen_frame();
      int n;
      n = int'(cfg_length);
      if (n > MAX_FRAME) n = MAX_FRAME;
      if (n < 4) n = 4;
      frame_buf = {};
      frame_buf.push_back(cfg_address);
      frame_buf.push_back(cfg_function);
      repeat (n - 4) frame_buf.push_back(8'($urandom_range(0, 255)));
      push_frame(1'b1, 1'b0);
   endtask

   initial begin : stimulus
      int phase;
      int target;
      logic [CSR_DATA_W-1:0] len_val;
      logic [CSR_DATA_W-1:0] tmo_val;
      wait (!reset);
      @(posedge clock);

      // Default registers: idle items, bad first byte, restart, drop, bad CRC
      push_item(ACTION_BYTE, 8'h01);
      push_item(ACTION_TICK, 8'hFF);
      push_item(ACTION_NONE, 8'hA5);
      push_item(ACTION_START, 8'h00);
      push_item(ACTION_BYTE, 8'h00);
      push_item(ACTION_BYTE, 8'h01);
      frame_buf = '{8'h01, 8'h03, 8'h00, 8'hFF, 8'h80};
      push_frame(1'b0, 1'b0);
      push_item(ACTION_START, 8'hFF);
      push_item(ACTION_BYTE, 8'h01);
      push_item(ACTION_BYTE, 8'h7E);
      push_item(ACTION_START, 8'h5A);
      frame_buf = '{8'h01, 8'h03, 8'hAA, 8'h55, 8'h12};
      push_frame(1'b0, 1'b1);
      wait_idle();

      // Zero length ends on the first byte; zero timeout ends on the first tick
      set_regs(16'h0000, 16'h00FF, 16'h0000, 16'h0000);
      push_item(ACTION_START, 8'h00);
      push_item(ACTION_BYTE, 8'h00);
      push_item(ACTION_START, 8'h00);
      push_item(ACTION_TICK, 8'h00);
      wait_idle();

      // Oversized length clips to the largest frame
      set_regs(16'h00FF, 16'h0000, 16'h001F, 16'hFFFF);
      push_item(ACTION_START, 8'h00);
      frame_buf = '{8'hFF, 8'h00};
      repeat (MAX_FRAME - 4) frame_buf.push_back(8'($urandom_range(0, 255)));
      push_frame(1'b0, 1'b0);
      push_item(ACTION_START, 8'h00);
      push_item(ACTION_BYTE, 8'hFF);
      repeat (3) push_item(ACTION_TICK, 8'h00);

      phase = 0;
      while (sent_total < ITEM_TARGET) begin
         wait_idle();
         case ($urandom_range(0, 9))
            0:       len_val = 16'($urandom_range(0, 3));
            1:       len_val = 16'(MAX_FRAME);
            2:       len_val = 16'($urandom_range(17, 31));
            default: len_val = 16'($urandom_range(4, 9));
         endcase
         len_val[15:LENGTH_W] = 11'($urandom_range(0, 2047));
         case ($urandom_range(0, 7))
            0:       tmo_val = 16'($urandom_range(0, 1));
            1:       tmo_val = 16'hFFFF;
            default: tmo_val = 16'($urandom_range(4, 60));
         endcase
         set_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), len_val, tmo_val);
         target = sent_total + int'($urandom_range(60, 120));
         while (sent_total < target) begin
            case ($urandom_range(0, 9))
               0, 1:
                  repeat ($urandom_range(1, 5))
                     push_item(action_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
               2: begin
                  push_item(ACTION_START, 8'($urandom_range(0, 255)));
                  push_item(ACTION_BYTE, cfg_address);
                  repeat ((cfg_timeout < 80) ? int'(cfg_timeout) + 1 : 40)
                     push_item(ACTION_TICK, 8'($urandom_range(0, 255)));
               end
               default: gen_frame();
            endcase
         end
         if (phase == 3) long_stall_arm = 1'b1;
         phase++;
      end
      wait_idle();

      if (err_cnt == 0 && frame_result_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
